FILE: rtl/lc3x_pkg.sv
// ----------------------------------------------------------------------------
// LC-3 subset execute unit package
// Shared types, opcode and trap vector codes, status codes and helpers.
// ----------------------------------------------------------------------------
package lc3x_pkg;

	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned WORD_W    = 16;

	localparam logic [WORD_W-1:0] RESET_PC = 16'h3000;

	// Opcodes from instruction bits 15:12.
	localparam logic [3:0] OP_ADD  = 4'b0001;
	localparam logic [3:0] OP_NOT  = 4'b1001;
	localparam logic [3:0] OP_LEA  = 4'b1110;
	localparam logic [3:0] OP_TRAP = 4'b1111;
	localparam logic [3:0] OP_RSVD = 4'b1101;

	// Trap vectors.
	localparam logic [7:0] VEC_CHAR_IN    = 8'h20;
	localparam logic [7:0] VEC_CHAR_OUT   = 8'h21;
	localparam logic [7:0] VEC_STRING_OUT = 8'h22;
	localparam logic [7:0] VEC_ECHO_IN    = 8'h23;
	localparam logic [7:0] VEC_PACKED_OUT = 8'h24;
	localparam logic [7:0] VEC_STOP       = 8'h25;

	localparam logic [5:0] NOT_PAD = 6'h3F;

	typedef enum logic [2:0] {
		ST_DONE        = 3'd0,
		ST_HALT        = 3'd1,
		ST_STRING      = 3'd2,
		ST_MALFORMED   = 3'd3,
		ST_UNIMPL_OP   = 3'd4,
		ST_UNIMPL_TRAP = 3'd5,
		ST_STOPPED     = 3'd6
	} status_t;

	// Instruction class decided by the decoder.
	typedef enum logic [3:0] {
		K_ADD_REG     = 4'd0,
		K_ADD_IMM     = 4'd1,
		K_NOT         = 4'd2,
		K_LEA         = 4'd3,
		K_HALT        = 4'd4,
		K_PUTS        = 4'd5,
		K_MALFORMED   = 4'd6,
		K_UNIMPL_OP   = 4'd7,
		K_UNIMPL_TRAP = 4'd8
	} kind_t;

	// Decoded instruction as it travels from decoder to execute stage.
	typedef struct packed {
		kind_t                kind;
		logic [REG_IDX_W-1:0] dr;
		logic [REG_IDX_W-1:0] sr1;
		logic [REG_IDX_W-1:0] sr2;
		logic [WORD_W-1:0]    imm;
	} uop_t;

	// One result item.
	typedef struct packed {
		logic [2:0]           flags_nzp;
		logic [WORD_W-1:0]    write_value;
		logic [REG_IDX_W-1:0] write_index;
		logic                 write_enable;
		logic [WORD_W-1:0]    next_pc;
		status_t              status;
	} result_t;

	function automatic logic [2:0] nzp_of(input logic [WORD_W-1:0] v);
		logic [2:0] f;
		if (v == '0) begin
			f = 3'b010;
		end else if (v[WORD_W-1]) begin
			f = 3'b100;
		end else begin
			f = 3'b001;
		end
		return f;
	endfunction

endpackage

FILE: rtl/lc3x_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module lc3x_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: rtl/lc3x_decode.sv
// ----------------------------------------------------------------------------
// Instruction decoder
// Classifies an instruction word and extracts register indexes and immediate.
// ----------------------------------------------------------------------------
module lc3x_decode (
	input  logic [15:0]          instruction,
	output lc3x_pkg::uop_t       uop
);

	logic [3:0] opcode;
	logic [7:0] vector;
	lc3x_pkg::kind_t kind;

	assign opcode = instruction[15:12];
	assign vector = instruction[7:0];

	always_comb begin
		kind = lc3x_pkg::K_UNIMPL_OP;
		case (opcode)
			lc3x_pkg::OP_ADD: begin
				if (instruction[5]) begin
					kind = lc3x_pkg::K_ADD_IMM;
				end else if (instruction[4:3] != 2'b00) begin
					kind = lc3x_pkg::K_MALFORMED;
				end else begin
					kind = lc3x_pkg::K_ADD_REG;
				end
			end
			lc3x_pkg::OP_NOT: begin
				if (instruction[5:0] == lc3x_pkg::NOT_PAD) begin
					kind = lc3x_pkg::K_NOT;
				end else begin
					kind = lc3x_pkg::K_MALFORMED;
				end
			end
			lc3x_pkg::OP_LEA: begin
				kind = lc3x_pkg::K_LEA;
			end
			lc3x_pkg::OP_TRAP: begin
				if (instruction[11:8] != 4'b0000) begin
					kind = lc3x_pkg::K_MALFORMED;
				end else begin
					case (vector)
						lc3x_pkg::VEC_STOP:       kind = lc3x_pkg::K_HALT;
						lc3x_pkg::VEC_STRING_OUT: kind = lc3x_pkg::K_PUTS;
						lc3x_pkg::VEC_CHAR_IN,
						lc3x_pkg::VEC_CHAR_OUT,
						lc3x_pkg::VEC_ECHO_IN,
						lc3x_pkg::VEC_PACKED_OUT: kind = lc3x_pkg::K_UNIMPL_TRAP;
						default:                  kind = lc3x_pkg::K_MALFORMED;
					endcase
				end
			end
			lc3x_pkg::OP_RSVD: begin
				kind = lc3x_pkg::K_MALFORMED;
			end
			default: begin
				kind = lc3x_pkg::K_UNIMPL_OP;
			end
		endcase
	end

	always_comb begin
		uop.kind = kind;
		uop.dr   = instruction[11:9];
		uop.sr1  = instruction[8:6];
		// A string request reads R0 through the second port.
		uop.sr2  = (kind == lc3x_pkg::K_PUTS) ? 3'd0 : instruction[2:0];
		if (kind == lc3x_pkg::K_LEA) begin
			uop.imm = {{7{instruction[8]}}, instruction[8:0]};
		end else begin
			uop.imm = {{11{instruction[4]}}, instruction[4:0]};
		end
	end

endmodule

FILE: rtl/lc3x_queue.sv
// ----------------------------------------------------------------------------
// Decoded instruction queue
// Two-entry FIFO between the decoder and the execute stage.
// ----------------------------------------------------------------------------
module lc3x_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lc3x_pkg::uop_t      push_uop,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output lc3x_pkg::uop_t      head_uop
);

	lc3x_pkg::uop_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head_uop  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/lc3x_execute.sv
// ----------------------------------------------------------------------------
// Execute stage
// Register file, program counter, flags and stop state; executes one
// decoded instruction per cycle, while the result slot is free or being drained, into a registered result slot.
// ----------------------------------------------------------------------------
module lc3x_execute (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_pc,
	input  logic                uop_valid,
	input  lc3x_pkg::uop_t      uop,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output lc3x_pkg::result_t   res
);

	// Operand read stage.
	logic              s1_valid_s1;
	lc3x_pkg::uop_t    uop_s1;
	logic              s1_load;
	logic              fire;

	// Register file and its reset-valid bits.
	logic [2:0]        raddr_a;
	logic [2:0]        raddr_b;
	logic [15:0]       rdata_a;
	logic [15:0]       rdata_b;
	logic [lc3x_pkg::NUM_REGS-1:0] rf_valid_q;
	logic              rvalid_a_q;
	logic              rvalid_b_q;

	// Write made at the edge that captured the current read data.
	logic              byp_we_q;
	logic [2:0]        byp_idx_q;
	logic [15:0]       byp_val_q;

	// Architectural state.
	logic [15:0]       pc_q;
	logic [2:0]        flags_q;
	logic              stopped_q;

	// Result slot.
	logic              out_valid_q;
	lc3x_pkg::result_t res_q;

	// Execute signals.
	logic [15:0]       op_a;
	logic [15:0]       op_b;
	logic [15:0]       pc_inc;
	lc3x_pkg::status_t status;
	logic              we;
	logic [2:0]        widx;
	logic [15:0]       wval;
	logic              flags_upd;
	logic [2:0]        flags_next;
	logic [15:0]       pc_next;
	logic              stop_next;

	function automatic lc3x_pkg::result_t res_next();
		lc3x_pkg::result_t r;
		r.status       = status;
		r.next_pc      = pc_next;
		r.write_enable = we;
		r.write_index  = widx;
		r.write_value  = wval;
		r.flags_nzp    = flags_next;
		return r;
	endfunction

	assign fire    = s1_valid_s1 && (!out_valid_q || res_ready);
	assign s1_load = !s1_valid_s1 || fire;
	assign pop     = s1_load && uop_valid;

	// Hold the read addresses while the stage is stalled so the data stays fresh.
	assign raddr_a = pop ? uop.sr1 : uop_s1.sr1;
	assign raddr_b = pop ? uop.sr2 : uop_s1.sr2;

	lc3x_ram #(
		.WIDTH (lc3x_pkg::WORD_W),
		.DEPTH (lc3x_pkg::NUM_REGS)
	) u_regfile (
		.clk     (clk),
		.we      (fire && we),
		.waddr   (widx),
		.wdata   (wval),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			uop_s1 <= uop;
		end
		byp_idx_q <= widx;
		byp_val_q <= wval;
		if (fire) begin
			res_q <= res_next();
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			rf_valid_q  <= '0;
			rvalid_a_q  <= 1'b0;
			rvalid_b_q  <= 1'b0;
			byp_we_q    <= 1'b0;
			pc_q        <= lc3x_pkg::RESET_PC;
			flags_q     <= 3'b000;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_s1 <= uop_valid;
			end
			rvalid_a_q <= rf_valid_q[raddr_a];
			rvalid_b_q <= rf_valid_q[raddr_b];
			byp_we_q   <= fire && we;
			if (fire) begin
				if (we) begin
					rf_valid_q[widx] <= 1'b1;
				end
				pc_q      <= pc_next;
				flags_q   <= flags_next;
				stopped_q <= stop_next;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				pc_q <= cfg_pc;
			end
		end
	end

	// Operands: a write at the capturing edge wins, a never-written register reads zero.
	always_comb begin
		if (byp_we_q && (byp_idx_q == uop_s1.sr1)) begin
			op_a = byp_val_q;
		end else begin
			op_a = rvalid_a_q ? rdata_a : 16'h0000;
		end
		if (byp_we_q && (byp_idx_q == uop_s1.sr2)) begin
			op_b = byp_val_q;
		end else begin
			op_b = rvalid_b_q ? rdata_b : 16'h0000;
		end
	end

	assign pc_inc = pc_q + 16'd1;

	always_comb begin
		status    = lc3x_pkg::ST_DONE;
		we        = 1'b0;
		widx      = 3'd0;
		wval      = 16'h0000;
		flags_upd = 1'b0;
		if (stopped_q) begin
			status = lc3x_pkg::ST_STOPPED;
		end else begin
			case (uop_s1.kind)
				lc3x_pkg::K_ADD_REG: begin
					we        = 1'b1;
					widx      = uop_s1.dr;
					wval      = op_a + op_b;
					flags_upd = 1'b1;
				end
				lc3x_pkg::K_ADD_IMM: begin
					we        = 1'b1;
					widx      = uop_s1.dr;
					wval      = op_a + uop_s1.imm;
					flags_upd = 1'b1;
				end
				lc3x_pkg::K_NOT: begin
					we        = 1'b1;
					widx      = uop_s1.dr;
					wval      = ~op_a;
					flags_upd = 1'b1;
				end
				lc3x_pkg::K_LEA: begin
					we   = 1'b1;
					widx = uop_s1.dr;
					wval = pc_inc + uop_s1.imm;
				end
				lc3x_pkg::K_HALT:        status = lc3x_pkg::ST_HALT;
				lc3x_pkg::K_PUTS: begin
					status = lc3x_pkg::ST_STRING;
					wval   = op_b;
				end
				lc3x_pkg::K_UNIMPL_OP:   status = lc3x_pkg::ST_UNIMPL_OP;
				lc3x_pkg::K_UNIMPL_TRAP: status = lc3x_pkg::ST_UNIMPL_TRAP;
				default:                 status = lc3x_pkg::ST_MALFORMED;
			endcase
		end
	end

	assign flags_next = flags_upd ? lc3x_pkg::nzp_of(wval) : flags_q;
	assign pc_next    = stopped_q ? pc_q : pc_inc;
	assign stop_next  = stopped_q || ((status != lc3x_pkg::ST_DONE) &&
	                                  (status != lc3x_pkg::ST_STRING));

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/lc3_subset_execute_unit.sv
// Each instruction passes through the queue, the operand read stage and the registered result slot.
// Throughput: one instruction per cycle while the result side accepts, bounded by the single execute stage
// that reads the register file, updates PC and flags and writes back.
// Reset: asynchronous and active low; clears the registers (read as zero until
// written), flags, stop state and the queue, and loads the PC with 0x3000.
// ----------------------------------------------------------------------------
// LC-3 subset execute unit
// Executes ADD, NOT, LEA and the HALT and PUTS traps, one result per
// instruction, and stops on malformed or unimplemented instructions.
// ----------------------------------------------------------------------------
module lc3_subset_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Instruction stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] instruction
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [2:0] status, [18:3] next_pc, [19] write_enable,
	                               // [22:20] write_index, [38:23] write_value,
	                               // [41:39] flags_nzp, [47:42] zero
	// Start address write; it also reloads the program counter.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// The front decodes each instruction as it arrives and parks it in a short
	// queue, so the input side keeps accepting while the result side is stalled, until the queue is full.
	lc3x_pkg::uop_t    dec_uop;
	lc3x_pkg::uop_t    head_uop;
	logic              q_full;
	logic              q_not_empty;
	logic              q_pop;
	lc3x_pkg::result_t res;

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;

	lc3x_decode u_decode (
		.instruction (s_tdata),
		.uop         (dec_uop)
	);

	lc3x_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_uop  (dec_uop),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_uop  (head_uop)
	);

	// The back reads operands into registers and executes from them once the result slot can take it, forwarding
	// a write-back that lands at the same edge as the operand read.
	lc3x_execute u_execute (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_pc    (cfg_data),
		.uop_valid (q_not_empty),
		.uop       (head_uop),
		.pop       (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Each transfer on the result side carries one packed result item.
	assign m_tdata = {6'b000000, res.flags_nzp, res.write_value, res.write_index,
	                  res.write_enable, res.next_pc, res.status};

endmodule
